@@ rtl/rtsm_pkg.sv @@
// ----------------------------------------------------------------------------
// rtsm_pkg
// Shared types and constants for the three-wire serial master.
// ----------------------------------------------------------------------------
package rtsm_pkg;

	// input kind codes as they arrive on the port
	localparam logic [1:0] KIND_TICK   = 2'd0;
	localparam logic [1:0] KIND_START  = 2'd1;
	localparam logic [1:0] KIND_SUPPLY = 2'd2;

	// configuration register indexes
	localparam logic CFG_BASE_OFFSET  = 1'b0;
	localparam logic CFG_BURST_OFFSET = 1'b1;

	localparam logic [6:0] BASE_OFFSET_RST  = 7'd64;
	localparam logic [6:0] BURST_OFFSET_RST = 7'd31;

	localparam int MAX_BURST_BYTES_DEF = 31;
	localparam int QUEUE_DEPTH         = 2;
	localparam int QUEUE_PTR_W         = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W         = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_TICK,
		OP_START,
		OP_SUPPLY,
		OP_NONE
	} op_kind_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_CMD,
		PH_WRITE,
		PH_READ
	} phase_t;

	// decoded item handed from front to back
	typedef struct packed {
		op_kind_t   op;
		logic       rd;
		logic [7:0] data;   // command byte on start, data byte on supply
		logic [4:0] count;
		logic       pin;
	} op_t;

	typedef struct packed {
		logic       chip_enable;
		logic       serial_clock;
		logic       data_out;
		logic       data_drive;
		logic [7:0] read_byte;
		logic       read_valid;
		logic       want_write_byte;
		logic       busy_res;
	} res_t;

endpackage

@@ rtl/three_wire_rtc_serial_master.sv @@
// ----------------------------------------------------------------------------
// three_wire_rtc_serial_master
// Tick-driven master for a three-wire clock-chip serial link, LSB first.
// ----------------------------------------------------------------------------
// Every input item (tick, start or write-byte supply) yields exactly one result
// carrying the line levels after that item. The block takes one item per clock
// cycle, sustained, while out_stall is low; a result waiting on out_stall lets
// three more items in behind it (input register and two-entry queue) before
// in_stall rises. An item passes an input register, a two-entry queue and the
// sequencer's output register, in that order; the sequencer updates the link
// state once per item. A tick is one half bit period: the first raises the
// serial clock, the second drops it and moves to the next bit. During a write
// the link waits with the clock low until the next byte is supplied
// (want_write_byte). The user must write the offsets through the cfg port only
// while no transfer is under way; the block itself does not enforce this.
module three_wire_rtc_serial_master #(
	parameter int MAX_BURST_BYTES = rtsm_pkg::MAX_BURST_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [6:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] kind,
	input  logic       read_op,
	input  logic       burst,
	input  logic [6:0] reg_address,
	input  logic [4:0] byte_count,
	input  logic [7:0] write_byte,
	input  logic       data_pin_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       chip_enable,
	output logic       serial_clock,
	output logic       data_out,
	output logic       data_drive,
	output logic [7:0] read_byte,
	output logic       read_valid,
	output logic       want_write_byte,
	output logic       busy_res
);

	logic           push;
	rtsm_pkg::op_t  push_op;
	logic           q_full;
	logic           pop;
	logic           head_valid;
	rtsm_pkg::op_t  head_op;
	rtsm_pkg::res_t res;

	rtsm_front #(
		.MAX_BURST_BYTES(MAX_BURST_BYTES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.read_op     (read_op),
		.burst       (burst),
		.reg_address (reg_address),
		.byte_count  (byte_count),
		.write_byte  (write_byte),
		.data_pin_in (data_pin_in),
		.push        (push),
		.push_op     (push_op),
		.q_full      (q_full)
	);

	rtsm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_op    (head_op)
	);

	rtsm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_op    (head_op),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.res        (res)
	);

	assign chip_enable     = res.chip_enable;
	assign serial_clock    = res.serial_clock;
	assign data_out        = res.data_out;
	assign data_drive      = res.data_drive;
	assign read_byte       = res.read_byte;
	assign read_valid      = res.read_valid;
	assign want_write_byte = res.want_write_byte;
	assign busy_res        = res.busy_res;

	// master only drives the line inside a transaction
	a_drive_in_txn: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && data_drive |-> busy_res && chip_enable)
		else $error("data line driven outside a transaction");

	// a completed read byte never coincides with the master driving the line
	a_read_released: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_valid |-> !data_drive && !serial_clock)
		else $error("read byte completed while line driven or clock high");

	// waiting for a write byte holds the clock low with the line driven
	a_wait_clock_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && want_write_byte |-> busy_res && data_drive && !serial_clock)
		else $error("clock not held low while waiting for write byte");

	// idle link keeps all lines quiet
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !busy_res |-> !chip_enable && !serial_clock && !data_out)
		else $error("link lines active while idle");

endmodule

@@ rtl/rtsm_front.sv @@
// ----------------------------------------------------------------------------
// rtsm_front
// Accepts input items, holds the offset registers, decodes each item and
// builds the command byte and byte count for a start.
// ----------------------------------------------------------------------------
module rtsm_front #(
	parameter int MAX_BURST_BYTES = rtsm_pkg::MAX_BURST_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [6:0]     cfg_data,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [1:0]     kind,
	input  logic           read_op,
	input  logic           burst,
	input  logic [6:0]     reg_address,
	input  logic [4:0]     byte_count,
	input  logic [7:0]     write_byte,
	input  logic           data_pin_in,
	output logic           push,
	output rtsm_pkg::op_t  push_op,
	input  logic           q_full
);

	logic [6:0]    base_offset_q;
	logic [6:0]    burst_offset_q;
	logic          valid_s1;
	rtsm_pkg::op_t op_s1;
	rtsm_pkg::op_t op_dec;
	logic [6:0]    addr;
	logic [4:0]    cnt;
	logic          accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_offset_q  <= rtsm_pkg::BASE_OFFSET_RST;
			burst_offset_q <= rtsm_pkg::BURST_OFFSET_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rtsm_pkg::CFG_BASE_OFFSET:  base_offset_q  <= cfg_data;
				rtsm_pkg::CFG_BURST_OFFSET: burst_offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		// 7-bit add wraps on its own
		addr = reg_address + base_offset_q + (burst ? burst_offset_q : 7'd0);
		cnt  = (!burst || byte_count == 5'd0) ? 5'd1 : byte_count;
		if (cnt > 5'(MAX_BURST_BYTES))
			cnt = 5'(MAX_BURST_BYTES);

		op_dec       = '0;
		op_dec.rd    = read_op;
		op_dec.count = cnt;
		op_dec.pin   = data_pin_in;
		unique case (kind)
			rtsm_pkg::KIND_TICK: begin
				op_dec.op = rtsm_pkg::OP_TICK;
			end
			rtsm_pkg::KIND_START: begin
				op_dec.op   = rtsm_pkg::OP_START;
				op_dec.data = {addr, read_op};
			end
			rtsm_pkg::KIND_SUPPLY: begin
				op_dec.op   = rtsm_pkg::OP_SUPPLY;
				op_dec.data = write_byte;
			end
			default: begin
				op_dec.op = rtsm_pkg::OP_NONE;
			end
		endcase
	end

	assign in_stall = valid_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign push     = valid_s1 && !q_full;
	assign push_op  = op_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			op_s1 <= op_dec;
	end

endmodule

@@ rtl/rtsm_queue.sv @@
// ----------------------------------------------------------------------------
// rtsm_queue
// Short queue of decoded items between the front and the link sequencer.
// ----------------------------------------------------------------------------
module rtsm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rtsm_pkg::op_t  push_op,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output rtsm_pkg::op_t  head_op
);

	rtsm_pkg::op_t                       mem [rtsm_pkg::QUEUE_DEPTH];
	logic [rtsm_pkg::QUEUE_PTR_W-1:0]    wr_ptr_q;
	logic [rtsm_pkg::QUEUE_PTR_W-1:0]    rd_ptr_q;
	logic [rtsm_pkg::QUEUE_CNT_W-1:0]    count_q;

	assign full       = count_q == rtsm_pkg::QUEUE_CNT_W'(rtsm_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_op    = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == rtsm_pkg::QUEUE_PTR_W'(rtsm_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == rtsm_pkg::QUEUE_PTR_W'(rtsm_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= push_op;
	end

endmodule

@@ rtl/rtsm_back.sv @@
// ----------------------------------------------------------------------------
// rtsm_back
// Link sequencer: steps the serial link once per decoded item and registers
// the line levels and read data in the output stage.
// ----------------------------------------------------------------------------
module rtsm_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  rtsm_pkg::op_t  head_op,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output rtsm_pkg::res_t res
);

	rtsm_pkg::phase_t phase_q, phase_n;
	logic [7:0]       shift_q, shift_n;
	logic [2:0]       bit_q, bit_n;
	logic             half_q, half_n;
	logic [4:0]       left_q, left_n;
	logic             reading_q, reading_n;
	logic             enable_q, enable_n;
	logic             pending_q, pending_n;
	logic             out_valid_q;
	rtsm_pkg::res_t   res_q;
	rtsm_pkg::res_t   res_n;
	logic             finish;

	assign pop       = head_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= rtsm_pkg::PH_IDLE;
			shift_q   <= '0;
			bit_q     <= '0;
			half_q    <= 1'b0;
			left_q    <= '0;
			reading_q <= 1'b0;
			enable_q  <= 1'b0;
			pending_q <= 1'b0;
		end else if (pop) begin
			phase_q   <= phase_n;
			shift_q   <= shift_n;
			bit_q     <= bit_n;
			half_q    <= half_n;
			left_q    <= left_n;
			reading_q <= reading_n;
			enable_q  <= enable_n;
			pending_q <= pending_n;
		end
	end

	always_comb begin
		phase_n   = phase_q;
		shift_n   = shift_q;
		bit_n     = bit_q;
		half_n    = half_q;
		left_n    = left_q;
		reading_n = reading_q;
		enable_n  = enable_q;
		pending_n = pending_q;
		finish    = 1'b0;
		res_n     = '0;

		unique case (head_op.op)
			rtsm_pkg::OP_TICK: begin
				// a write with no byte supplied yet holds the link
				if (phase_q != rtsm_pkg::PH_IDLE &&
				    !(phase_q == rtsm_pkg::PH_WRITE && !pending_q)) begin
					if (!half_q) begin
						// sample just before the rising clock
						if (phase_q == rtsm_pkg::PH_READ && head_op.pin)
							shift_n[bit_q] = 1'b1;
						half_n = 1'b1;
					end else begin
						half_n = 1'b0;
						if (phase_q != rtsm_pkg::PH_READ)
							shift_n = {1'b0, shift_q[7:1]};
						bit_n = bit_q + 3'd1;
						if (bit_n == 3'd0) begin
							unique case (phase_q)
								rtsm_pkg::PH_CMD: begin
									shift_n = '0;
									if (reading_q) begin
										phase_n = rtsm_pkg::PH_READ;
									end else begin
										phase_n   = rtsm_pkg::PH_WRITE;
										pending_n = 1'b0;
									end
								end
								rtsm_pkg::PH_WRITE: begin
									pending_n = 1'b0;
									finish    = 1'b1;
								end
								rtsm_pkg::PH_READ: begin
									res_n.read_byte  = shift_q;
									res_n.read_valid = 1'b1;
									shift_n          = '0;
									finish           = 1'b1;
								end
								default: ;
							endcase
						end
					end
				end
			end
			rtsm_pkg::OP_START: begin
				if (phase_q == rtsm_pkg::PH_IDLE) begin
					shift_n   = head_op.data;
					bit_n     = '0;
					half_n    = 1'b0;
					left_n    = head_op.count;
					reading_n = head_op.rd;
					enable_n  = 1'b1;
					pending_n = 1'b0;
					phase_n   = rtsm_pkg::PH_CMD;
				end
			end
			rtsm_pkg::OP_SUPPLY: begin
				if (phase_q == rtsm_pkg::PH_WRITE && !pending_q) begin
					shift_n   = head_op.data;
					pending_n = 1'b1;
					bit_n     = '0;
					half_n    = 1'b0;
				end
			end
			default: ;
		endcase

		if (finish) begin
			if (left_q != 5'd0)
				left_n = left_q - 5'd1;
			if (left_n == 5'd0) begin
				phase_n   = rtsm_pkg::PH_IDLE;
				enable_n  = 1'b0;
				reading_n = 1'b0;
				shift_n   = '0;
				pending_n = 1'b0;
			end
		end

		res_n.chip_enable  = enable_n;
		res_n.serial_clock = (phase_n != rtsm_pkg::PH_IDLE) && half_n;
		res_n.data_drive   = phase_n == rtsm_pkg::PH_CMD || phase_n == rtsm_pkg::PH_WRITE;
		res_n.data_out     = (phase_n == rtsm_pkg::PH_CMD ||
		                      (phase_n == rtsm_pkg::PH_WRITE && pending_n)) && shift_n[0];
		res_n.want_write_byte = phase_n == rtsm_pkg::PH_WRITE && !pending_n;
		res_n.busy_res     = phase_n != rtsm_pkg::PH_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			res_q <= res_n;
	end

endmodule

@@ bench/three_wire_rtc_serial_master_checker.sv @@
// ----------------------------------------------------------------------------
// three_wire_rtc_serial_master_checker
// Watches both channels of the serial master, predicts the line levels after
// every accepted transfer and compares each result field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module three_wire_rtc_serial_master_checker
	import rtsm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [6:0] cfg_data,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [1:0] kind,
	input  logic       read_op,
	input  logic       burst,
	input  logic [6:0] reg_address,
	input  logic [4:0] byte_count,
	input  logic [7:0] write_byte,
	input  logic       data_pin_in,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic       chip_enable,
	input  logic       serial_clock,
	input  logic       data_out,
	input  logic       data_drive,
	input  logic [7:0] read_byte,
	input  logic       read_valid,
	input  logic       want_write_byte,
	input  logic       busy_res,
	output int         failures,
	output int         outstanding,
	output logic       link_idle,
	output int         checked,
	output int         bytes_read,
	output int         starts_taken
);

	// mirror of the link sequencer
	logic [6:0] base_off;
	logic [6:0] burst_off;
	phase_t     lk_phase;
	logic [7:0] lk_shift;
	logic [2:0] lk_bit;
	logic       lk_half;
	logic [4:0] lk_left;
	logic       lk_reading;
	logic       lk_enable;
	logic       lk_pending;

	res_t line_q[$];

	task automatic count_byte();
		if (lk_left != 5'd0)
			lk_left = lk_left - 5'd1;
		if (lk_left == 5'd0) begin
			lk_phase   = PH_IDLE;
			lk_enable  = 1'b0;
			lk_reading = 1'b0;
			lk_shift   = '0;
			lk_pending = 1'b0;
		end
	endtask

	task automatic advance_link(input logic [1:0] k, input logic rd, input logic bu,
			input logic [6:0] addr, input logic [4:0] cnt, input logic [7:0] wb,
			input logic pin, output res_t r);
		logic [6:0] cmd_addr;
		logic [4:0] nbytes;
		r = '0;
		case (k)
		KIND_TICK: begin
			// idle, or waiting for a write byte: the tick does nothing
			if (lk_phase != PH_IDLE && !(lk_phase == PH_WRITE && !lk_pending)) begin
				if (!lk_half) begin
					if (lk_phase == PH_READ && pin)
						lk_shift[lk_bit] = 1'b1;
					lk_half = 1'b1;
				end else begin
					lk_half = 1'b0;
					if (lk_phase != PH_READ)
						lk_shift = lk_shift >> 1;
					lk_bit = lk_bit + 3'd1;
					if (lk_bit == 3'd0) begin
						case (lk_phase)
						PH_CMD: begin
							lk_shift = '0;
							if (lk_reading)
								lk_phase = PH_READ;
							else begin
								lk_phase   = PH_WRITE;
								lk_pending = 1'b0;
							end
						end
						PH_WRITE: begin
							lk_pending = 1'b0;
							count_byte();
						end
						default: begin
							r.read_byte  = lk_shift;
							r.read_valid = 1'b1;
							bytes_read++;
							lk_shift = '0;
							count_byte();
						end
						endcase
					end
				end
			end
		end
		KIND_START: begin
			if (lk_phase == PH_IDLE) begin
				// command address wraps at seven bits
				cmd_addr = addr + base_off + (bu ? burst_off : 7'd0);
				nbytes = (!bu || cnt == 5'd0) ? 5'd1 : cnt;
				if (nbytes > MAX_BURST_BYTES_DEF)
					nbytes = 5'(MAX_BURST_BYTES_DEF);
				lk_shift   = {cmd_addr, rd};
				lk_bit     = '0;
				lk_half    = 1'b0;
				lk_left    = nbytes;
				lk_reading = rd;
				lk_enable  = 1'b1;
				lk_pending = 1'b0;
				lk_phase   = PH_CMD;
				starts_taken++;
			end
		end
		KIND_SUPPLY: begin
			if (lk_phase == PH_WRITE && !lk_pending) begin
				lk_shift   = wb;
				lk_pending = 1'b1;
				lk_bit     = '0;
				lk_half    = 1'b0;
			end
		end
		default: ;
		endcase

		r.chip_enable     = lk_enable;
		r.serial_clock    = (lk_phase != PH_IDLE) ? lk_half : 1'b0;
		r.data_drive      = (lk_phase == PH_CMD || lk_phase == PH_WRITE);
		r.data_out        = (lk_phase == PH_CMD || (lk_phase == PH_WRITE && lk_pending)) ?
			lk_shift[0] : 1'b0;
		r.want_write_byte = (lk_phase == PH_WRITE && !lk_pending);
		r.busy_res        = (lk_phase != PH_IDLE);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t fresh;
		res_t due;
		if (!arst_n) begin
			base_off     = BASE_OFFSET_RST;
			burst_off    = BURST_OFFSET_RST;
			lk_phase     = PH_IDLE;
			lk_shift     = '0;
			lk_bit       = '0;
			lk_half      = 1'b0;
			lk_left      = '0;
			lk_reading   = 1'b0;
			lk_enable    = 1'b0;
			lk_pending   = 1'b0;
			line_q.delete();
			failures     = 0;
			outstanding  = 0;
			link_idle    = 1'b1;
			checked      = 0;
			bytes_read   = 0;
			starts_taken = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_BASE_OFFSET)
					base_off = cfg_data;
				else
					burst_off = cfg_data;
			end
			if (in_valid && !in_stall) begin
				advance_link(kind, read_op, burst, reg_address, byte_count, write_byte,
					data_pin_in, fresh);
				line_q.push_back(fresh);
			end
			if (out_valid && !out_stall) begin
				if (line_q.size() == 0) begin
					$error("result transfer with no prediction waiting");
					failures++;
				end else begin
					due = line_q.pop_front();
					check_field("chip_enable", due.chip_enable, chip_enable);
					check_field("serial_clock", due.serial_clock, serial_clock);
					check_field("data_out", due.data_out, data_out);
					check_field("data_drive", due.data_drive, data_drive);
					check_field("read_byte", due.read_byte, read_byte);
					check_field("read_valid", due.read_valid, read_valid);
					check_field("want_write_byte", due.want_write_byte, want_write_byte);
					check_field("busy_res", due.busy_res, busy_res);
					checked++;
				end
			end
			outstanding = line_q.size();
			link_idle   = (lk_phase == PH_IDLE);
		end
	end

endmodule

@@ bench/three_wire_rtc_serial_master_test.sv @@
// ----------------------------------------------------------------------------
// three_wire_rtc_serial_master_test
// Drives read and write transactions, single and burst, through the serial
// master under several idling patterns; the checker predicts every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module three_wire_rtc_serial_master_test;
	import rtsm_pkg::*;

	localparam int PINS_LOW    = 0;
	localparam int PINS_HIGH   = 1;
	localparam int PINS_RANDOM = 2;
	localparam int NO_CUT      = 1 << 30;
	localparam int HOLD_CYCLES = 200;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	logic [6:0] cfg_data;
	logic       in_valid;
	logic       in_stall;
	logic [1:0] kind;
	logic       read_op;
	logic       burst;
	logic [6:0] reg_address;
	logic [4:0] byte_count;
	logic [7:0] write_byte;
	logic       data_pin_in;
	logic       out_valid;
	logic       out_stall;
	logic       chip_enable;
	logic       serial_clock;
	logic       data_out;
	logic       data_drive;
	logic [7:0] read_byte;
	logic       read_valid;
	logic       want_write_byte;
	logic       busy_res;

	int   failures;
	int   outstanding;
	logic link_idle;
	int   checked;
	int   bytes_read;
	int   starts_taken;

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int items_sent    = 0;
	int cut_ticks     = NO_CUT;
	int hold_req      = 0;

	three_wire_rtc_serial_master dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .read_op(read_op), .burst(burst), .reg_address(reg_address),
		.byte_count(byte_count), .write_byte(write_byte), .data_pin_in(data_pin_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.chip_enable(chip_enable), .serial_clock(serial_clock), .data_out(data_out),
		.data_drive(data_drive), .read_byte(read_byte), .read_valid(read_valid),
		.want_write_byte(want_write_byte), .busy_res(busy_res)
	);

	three_wire_rtc_serial_master_checker link_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .read_op(read_op), .burst(burst), .reg_address(reg_address),
		.byte_count(byte_count), .write_byte(write_byte), .data_pin_in(data_pin_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.chip_enable(chip_enable), .serial_clock(serial_clock), .data_out(data_out),
		.data_drive(data_drive), .read_byte(read_byte), .read_valid(read_valid),
		.want_write_byte(want_write_byte), .busy_res(busy_res),
		.failures(failures), .outstanding(outstanding), .link_idle(link_idle),
		.checked(checked), .bytes_read(bytes_read), .starts_taken(starts_taken)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int hold_seen;
		hold_seen = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else
				out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	initial begin
		#5_000_000;
		$display("three_wire_rtc_serial_master_test NOT OK");
		$finish;
	end

	// one input transfer; entered and left just after a falling edge
	task automatic send_item(input logic [1:0] k, input logic rd, input logic bu,
			input logic [6:0] addr, input logic [4:0] cnt, input logic [7:0] wb,
			input logic pin);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		kind        <= k;
		read_op     <= rd;
		burst       <= bu;
		reg_address <= addr;
		byte_count  <= cnt;
		write_byte  <= wb;
		data_pin_in <= pin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_tick(input logic pin);
		send_item(KIND_TICK, 1'($urandom), 1'($urandom), 7'($urandom), 5'($urandom),
			8'($urandom), pin);
	endtask

	// stray items: start while busy, unwanted supply, unknown kind
	task automatic send_noise(input bit allow_start);
		case ($urandom_range(allow_start ? 2 : 1))
		0: send_item(OP_NONE, 1'($urandom), 1'($urandom), 7'($urandom), 5'($urandom),
			8'($urandom), 1'($urandom));
		1: send_item(KIND_SUPPLY, 1'($urandom), 1'($urandom), 7'($urandom), 5'($urandom),
			8'($urandom), 1'($urandom));
		default: send_item(KIND_START, 1'($urandom), 1'($urandom), 7'($urandom),
			5'($urandom), 8'($urandom), 1'($urandom));
		endcase
	endtask

	task automatic run_ticks(input int n, input int pins, input int noise_pct);
		for (int i = 0; i < n; i++) begin
			if (cut_ticks == 0)
				return;
			cut_ticks--;
			if ($urandom_range(99) < noise_pct)
				send_noise(1'b1);
			send_tick(pins == PINS_RANDOM ? 1'($urandom_range(1)) : pins[0]);
		end
	endtask

	task automatic run_xfer(input logic rd, input logic bu, input logic [6:0] addr,
			input logic [4:0] cnt, input logic [7:0] first_byte, input bit data_rand,
			input int pins, input int noise_pct);
		int nbytes;
		logic [7:0] wb;
		nbytes = (!bu || cnt == 5'd0) ? 1 : int'(cnt);
		send_item(KIND_START, rd, bu, addr, cnt, 8'($urandom), 1'($urandom));
		run_ticks(16, PINS_RANDOM, noise_pct);
		for (int b = 0; b < nbytes; b++) begin
			if (cut_ticks == 0)
				return;
			if (!rd) begin
				// ticks before the byte arrives leave the clock low
				if ($urandom_range(3) == 0)
					run_ticks($urandom_range(3, 1), PINS_RANDOM, 0);
				wb = data_rand ? 8'($urandom) : (b[0] ? ~first_byte : first_byte);
				send_item(KIND_SUPPLY, 1'($urandom), 1'($urandom), 7'($urandom),
					5'($urandom), wb, 1'($urandom));
				run_ticks(16, PINS_RANDOM, noise_pct);
			end else
				run_ticks(16, pins, noise_pct);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	// bring the link back to idle so the offsets may change
	task automatic finish_link();
		cut_ticks = NO_CUT;
		drain();
		while (!link_idle) begin
			send_item(KIND_SUPPLY, 1'($urandom), 1'($urandom), 7'($urandom),
				5'($urandom), 8'($urandom), 1'($urandom));
			run_ticks(16, PINS_RANDOM, 0);
			drain();
		end
	endtask

	task automatic write_reg(input logic idx, input logic [6:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_phase(input int idle, input int stall, input int n_items,
			input bit with_hold);
		int first;
		int cnt;
		send_idle_pct = idle;
		stall_pct     = stall;
		first         = items_sent;
		while (items_sent - first < n_items) begin
			if (with_hold && items_sent - first > n_items / 3 && hold_req == 0)
				hold_req++;
			case ($urandom_range(99)) inside
			[0:84]:  cnt = $urandom_range(4, 1);
			[85:96]: cnt = $urandom_range(1) ? 0 : $urandom_range(12, 5);
			default: cnt = $urandom_range(31, 13);
			endcase
			// a few transactions are cut short and left for the next one to run into
			cut_ticks = ($urandom_range(99) < 8) ? $urandom_range(40, 1) : NO_CUT;
			if ($urandom_range(99) < 15)
				send_noise(1'b0);
			run_xfer(1'($urandom_range(1)), 1'($urandom_range(1)), 7'($urandom), 5'(cnt),
				8'($urandom), 1'b1, PINS_RANDOM, 5);
			cut_ticks = NO_CUT;
		end
		finish_link();
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = CFG_BASE_OFFSET;
		cfg_data    = '0;
		in_valid    = 1'b0;
		kind        = KIND_TICK;
		read_op     = 1'b0;
		burst       = 1'b0;
		reg_address = '0;
		byte_count  = '0;
		write_byte  = '0;
		data_pin_in = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: items while idle, then the corner transactions
		send_tick(1'b1);
		send_item(OP_NONE, 1'b1, 1'b1, 7'h7f, 5'h1f, 8'hff, 1'b1);
		send_item(KIND_SUPPLY, 1'b0, 1'b0, 7'h00, 5'h00, 8'hff, 1'b0);
		// single write at the top address, byte count ignored, with stray items
		run_xfer(1'b0, 1'b0, 7'h7f, 5'h1f, 8'ha5, 1'b0, PINS_RANDOM, 30);
		run_xfer(1'b1, 1'b0, 7'h00, 5'h00, 8'h00, 1'b0, PINS_HIGH, 0);
		finish_link();
		write_reg(CFG_BASE_OFFSET, 7'h00);
		write_reg(CFG_BURST_OFFSET, 7'h00);
		// burst with a zero count moves one byte
		run_xfer(1'b1, 1'b1, 7'h00, 5'h00, 8'h00, 1'b0, PINS_LOW, 0);
		run_xfer(1'b1, 1'b1, 7'h55, 5'h04, 8'h00, 1'b0, PINS_RANDOM, 0);
		finish_link();
		write_reg(CFG_BASE_OFFSET, 7'h7f);
		write_reg(CFG_BURST_OFFSET, 7'h7f);
		// address wraps past seven bits
		run_xfer(1'b0, 1'b1, 7'h7f, 5'h02, 8'h00, 1'b0, PINS_RANDOM, 0);
		finish_link();

		write_reg(CFG_BASE_OFFSET, 7'($urandom));
		write_reg(CFG_BURST_OFFSET, 7'($urandom));
		run_phase(0, 0, 40, 1'b1);
		write_reg(CFG_BASE_OFFSET, 7'h00);
		write_reg(CFG_BURST_OFFSET, 7'h7f);
		run_phase(82, 0, 40, 1'b0);
		write_reg(CFG_BASE_OFFSET, 7'h7f);
		write_reg(CFG_BURST_OFFSET, 7'h00);
		run_phase(0, 82, 40, 1'b0);
		write_reg(CFG_BASE_OFFSET, 7'($urandom));
		write_reg(CFG_BURST_OFFSET, 7'($urandom));
		run_phase(12, 12, 40, 1'b0);

		drain();
		repeat (10) @(negedge clk);
		$display("sent %0d items, checked %0d results: %0d transactions started, %0d bytes read",
			items_sent, checked, starts_taken, bytes_read);
		if (failures == 0 && outstanding == 0)
			$display("three_wire_rtc_serial_master_test OK");
		else
			$display("three_wire_rtc_serial_master_test NOT OK");
		$finish;
	end

endmodule
